// ===== src/fwpe_pkg.sv =====
// Shared types and constants for the priority-extract queue.
// Holds request and status codes, field widths and the control state type.
// No dependencies.
package fwpe_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int HANDLE_W   = 32;
    localparam int PRIO_W     = 8;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;
    localparam int ENTRY_W    = HANDLE_W + PRIO_W;

    localparam logic [REQ_W-1:0] REQ_PUSH       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP        = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE_MIN = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_FREE,
        ST_SCAN,
        ST_UNLINK,
        ST_RELINK,
        ST_DONE
    } t_state;

endpackage

// ===== src/fwpe_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered; contents are not reset.
// No dependencies.
module fwpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/fifo_with_priority_extract.sv =====
// Ordered queue with pop-head and remove-lowest-priority, one request at a time.
// The scan for a priority removal reads one entry per cycle from the RAMs. A new request
// is taken once the previous result sits in the output register. Synchronous active-low
// reset empties the queue; RAM contents need no clearing.
module fifo_with_priority_extract #(
    parameter int QUEUE_DEPTH = fwpe_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [31:0] entry_handle, [39:32] entry_priority
    input  logic [fwpe_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [fwpe_pkg::REQ_W-1:0]     i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [31:0] out_handle, [36:32] entry_count, [39:37] zero
    output logic [fwpe_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] out_valid, [2:1] status
    output logic [fwpe_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int LW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = (CW > fwpe_pkg::COUNT_W) ? CW : fwpe_pkg::COUNT_W;
    localparam int HW = fwpe_pkg::HANDLE_W;
    localparam int PW = fwpe_pkg::PRIO_W;
    localparam int EW = fwpe_pkg::ENTRY_W;

    fwpe_pkg::t_state r_state, n_state;

    // queue control
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fresh, n_fresh;      // slots ever allocated
    logic [LW-1:0] r_free_head, n_free_head;

    // request and scan state
    logic [HW-1:0] r_in_handle, n_in_handle;
    logic [PW-1:0] r_in_prio, n_in_prio;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_best, n_best;
    logic [LW-1:0] r_best_prev, n_best_prev;
    logic          r_best_head, n_best_head;
    logic [PW-1:0] r_best_prio, n_best_prio;
    logic [CW-1:0] r_k, n_k;
    logic [LW-1:0] r_next, n_next;

    // pending result
    logic [HW-1:0]                 r_res_handle, n_res_handle;
    logic                          r_res_valid, n_res_valid;
    logic [fwpe_pkg::STATUS_W-1:0] r_res_status, n_res_status;

    // output register
    logic                          r_m_valid, n_m_valid;
    logic [HW-1:0]                 r_out_handle, n_out_handle;
    logic                          r_out_valid, n_out_valid;
    logic [fwpe_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [fwpe_pkg::COUNT_W-1:0]  r_out_count, n_out_count;

    // memory ports
    logic [LW-1:0] w_rd_addr;
    logic          w_data_we;
    logic [LW-1:0] w_data_waddr;
    logic [EW-1:0] w_data_wdata;
    logic [EW-1:0] w_data_rd;
    logic          w_link_we;
    logic [LW-1:0] w_link_waddr;
    logic [LW-1:0] w_link_wdata;
    logic [LW-1:0] w_link_rd;

    logic [fwpe_pkg::REQ_W-1:0] w_req;
    logic [HW-1:0]              w_in_handle;
    logic [PW-1:0]              w_in_prio;
    logic [XW-1:0]              w_count_x;

    assign w_req       = i_s_axis_tuser;
    assign w_in_handle = i_s_axis_tdata[HW-1:0];
    assign w_in_prio   = i_s_axis_tdata[HW+PW-1:HW];
    assign w_count_x   = XW'(n_count);

    fwpe_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (LW)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_data_we),
        .i_wr_addr (w_data_waddr),
        .i_wr_data (w_data_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_data_rd)
    );

    // one chain per slot: queue order for held entries, free list for released ones
    fwpe_ram #(
        .WIDTH (LW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (LW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_link_we),
        .i_wr_addr (w_link_waddr),
        .i_wr_data (w_link_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_link_rd)
    );

    always_comb begin
        logic [LW-1:0] v_slot;
        logic [PW-1:0] v_prio;
        logic [CW-1:0] v_k_next;

        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fresh      = r_fresh;
        n_free_head  = r_free_head;
        n_in_handle  = r_in_handle;
        n_in_prio    = r_in_prio;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_best       = r_best;
        n_best_prev  = r_best_prev;
        n_best_head  = r_best_head;
        n_best_prio  = r_best_prio;
        n_k          = r_k;
        n_next       = r_next;
        n_res_handle = r_res_handle;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid && !i_m_axis_tready;
        n_out_handle = r_out_handle;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;

        w_rd_addr    = r_cur;
        w_data_we    = 1'b0;
        w_data_waddr = '0;
        w_data_wdata = '0;
        w_link_we    = 1'b0;
        w_link_waddr = '0;
        w_link_wdata = '0;

        v_slot   = r_fresh[LW-1:0];
        v_prio   = w_data_rd[EW-1:HW];
        v_k_next = r_k + 1'b1;

        o_s_axis_tready = (r_state == fwpe_pkg::ST_IDLE);

        case (r_state)
            fwpe_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_in_handle  = w_in_handle;
                    n_in_prio    = w_in_prio;
                    n_res_handle = '0;
                    n_res_valid  = 1'b0;
                    n_res_status = fwpe_pkg::STAT_OK;
                    n_state      = fwpe_pkg::ST_DONE;
                    case (w_req)
                        fwpe_pkg::REQ_PUSH: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_res_status = fwpe_pkg::STAT_FULL;
                            end else if (r_fresh != r_count) begin
                                // reuse a released slot: fetch its free-list link
                                w_rd_addr = r_free_head;
                                n_state   = fwpe_pkg::ST_PUSH_FREE;
                            end else begin
                                w_data_we    = 1'b1;
                                w_data_waddr = v_slot;
                                w_data_wdata = {w_in_prio, w_in_handle};
                                if (r_count != '0) begin
                                    w_link_we    = 1'b1;
                                    w_link_waddr = r_tail;
                                    w_link_wdata = v_slot;
                                end else begin
                                    n_head = v_slot;
                                end
                                n_tail  = v_slot;
                                n_count = r_count + 1'b1;
                                n_fresh = r_fresh + 1'b1;
                            end
                        end
                        fwpe_pkg::REQ_POP, fwpe_pkg::REQ_REMOVE_MIN: begin
                            if (r_count == '0) begin
                                n_res_status = fwpe_pkg::STAT_EMPTY;
                            end else begin
                                w_rd_addr   = r_head;
                                n_cur       = r_head;
                                n_prev      = r_head;
                                n_best      = r_head;
                                n_best_prev = r_head;
                                n_best_head = 1'b1;
                                n_k         = '0;
                                n_state     = (w_req == fwpe_pkg::REQ_POP) ?
                                              fwpe_pkg::ST_UNLINK : fwpe_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = fwpe_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            fwpe_pkg::ST_PUSH_FREE: begin
                v_slot       = r_free_head;
                n_free_head  = w_link_rd;
                w_data_we    = 1'b1;
                w_data_waddr = v_slot;
                w_data_wdata = {r_in_prio, r_in_handle};
                if (r_count != '0) begin
                    w_link_we    = 1'b1;
                    w_link_waddr = r_tail;
                    w_link_wdata = v_slot;
                end else begin
                    n_head = v_slot;
                end
                n_tail  = v_slot;
                n_count = r_count + 1'b1;
                n_state = fwpe_pkg::ST_DONE;
            end
            fwpe_pkg::ST_SCAN: begin
                // entry at r_cur is on the read ports; keep the first minimum
                if (r_k == '0) begin
                    n_best_prio = v_prio;
                end else if (v_prio < r_best_prio) begin
                    n_best      = r_cur;
                    n_best_prev = r_prev;
                    n_best_head = 1'b0;
                    n_best_prio = v_prio;
                end
                n_prev = r_cur;
                n_k    = v_k_next;
                if (v_k_next == r_count) begin
                    w_rd_addr = n_best;
                    n_state   = fwpe_pkg::ST_UNLINK;
                end else begin
                    w_rd_addr = w_link_rd;
                    n_cur     = w_link_rd;
                end
            end
            fwpe_pkg::ST_UNLINK: begin
                n_res_handle = w_data_rd[HW-1:0];
                n_res_valid  = 1'b1;
                n_next       = w_link_rd;
                // push the slot onto the free list
                w_link_we    = 1'b1;
                w_link_waddr = r_best;
                w_link_wdata = r_free_head;
                n_free_head  = r_best;
                if (r_best_head) begin
                    n_head = w_link_rd;
                end
                if (r_best == r_tail) begin
                    n_tail = r_best_prev;
                end
                n_count = r_count - 1'b1;
                n_state = r_best_head ? fwpe_pkg::ST_DONE : fwpe_pkg::ST_RELINK;
            end
            fwpe_pkg::ST_RELINK: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_best_prev;
                w_link_wdata = r_next;
                n_state      = fwpe_pkg::ST_DONE;
            end
            fwpe_pkg::ST_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid    = 1'b1;
                    n_out_handle = r_res_handle;
                    n_out_valid  = r_res_valid;
                    n_out_status = r_res_status;
                    n_out_count  = w_count_x[fwpe_pkg::COUNT_W-1:0];
                    n_state      = fwpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fwpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwpe_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_handle  <= n_in_handle;
        r_in_prio    <= n_in_prio;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_best       <= n_best;
        r_best_prev  <= n_best_prev;
        r_best_head  <= n_best_head;
        r_best_prio  <= n_best_prio;
        r_k          <= n_k;
        r_next       <= n_next;
        r_res_handle <= n_res_handle;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
        r_out_handle <= n_out_handle;
        r_out_valid  <= n_out_valid;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {
        (fwpe_pkg::M_TDATA_W - HW - fwpe_pkg::COUNT_W)'(0), r_out_count, r_out_handle
    };
    assign o_m_axis_tuser  = {r_out_status, r_out_valid};

endmodule

// ===== sim/tb_fifo_with_priority_extract.sv =====
// Testbench for the queue: directed table, fill-and-drain hold, random idle/stall traffic.
// Results are checked against typed table rows or a behavioral queue kept inside the bench.
// Depends on fwpe_pkg and fifo_with_priority_extract from src.
module tb_fifo_with_priority_extract;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = fwpe_pkg::DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 50;
    localparam int PHASE_ITEMS = 350;

    // request code the block must ignore
    localparam logic [fwpe_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [fwpe_pkg::HANDLE_W-1:0] handle;
        logic [fwpe_pkg::PRIO_W-1:0]   prio;
    } t_entry;

    typedef struct packed {
        logic [fwpe_pkg::HANDLE_W-1:0] handle;
        logic                          valid;
        logic [fwpe_pkg::STATUS_W-1:0] status;
        logic [fwpe_pkg::COUNT_W-1:0]  count;
    } t_result;

    typedef struct packed {
        logic [fwpe_pkg::REQ_W-1:0]    req;
        logic [fwpe_pkg::HANDLE_W-1:0] handle;
        logic [fwpe_pkg::PRIO_W-1:0]   prio;
        logic                          typed;
        t_result                       want;
    } t_table_row;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [fwpe_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [fwpe_pkg::REQ_W-1:0]     s_tuser = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [fwpe_pkg::M_TDATA_W-1:0] m_tdata;
    logic [fwpe_pkg::M_TUSER_W-1:0] m_tuser;

    t_entry  held_entries[$];
    t_result pending_results[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int beats_seen    = 0;
    int pushes_stored = 0;
    int full_refusals = 0;
    int entries_taken = 0;
    int empty_results = 0;
    int ignored_reqs  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;

    fifo_with_priority_extract #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h (cycle %0d, beat %0d)",
                 what, got, want, cycle_count, beats_seen);
        fail_count++;
    endtask

    // Apply one accepted request to the queue and return the result it should produce.
    function automatic t_result queue_outcome(input logic [fwpe_pkg::REQ_W-1:0] req,
                                              input logic [fwpe_pkg::HANDLE_W-1:0] handle,
                                              input logic [fwpe_pkg::PRIO_W-1:0] prio);
        t_result r;
        int      pick;
        t_entry  e;
        r = '{handle: '0, valid: 1'b0, status: fwpe_pkg::STAT_OK, count: '0};
        case (req)
            fwpe_pkg::REQ_PUSH: begin
                if (held_entries.size() >= DEPTH) begin
                    r.status = fwpe_pkg::STAT_FULL;
                    full_refusals++;
                end else begin
                    e.handle = handle;
                    e.prio   = prio;
                    held_entries.push_back(e);
                    pushes_stored++;
                end
            end
            fwpe_pkg::REQ_POP, fwpe_pkg::REQ_REMOVE_MIN: begin
                if (held_entries.size() == 0) begin
                    r.status = fwpe_pkg::STAT_EMPTY;
                    empty_results++;
                end else begin
                    pick = 0;
                    // first entry with the smallest priority value wins ties
                    if (req == fwpe_pkg::REQ_REMOVE_MIN) begin
                        for (int k = 1; k < held_entries.size(); k++)
                            if (held_entries[k].prio < held_entries[pick].prio)
                                pick = k;
                    end
                    r.handle = held_entries[pick].handle;
                    r.valid  = 1'b1;
                    held_entries.delete(pick);
                    entries_taken++;
                end
            end
            default: ignored_reqs++;
        endcase
        r.count = fwpe_pkg::COUNT_W'(held_entries.size());
        return r;
    endfunction

    task automatic send_request(input logic [fwpe_pkg::REQ_W-1:0] req,
                                input logic [fwpe_pkg::HANDLE_W-1:0] handle,
                                input logic [fwpe_pkg::PRIO_W-1:0] prio, input logic typed,
                                input t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {prio, handle};
        s_tuser <= req;
        do @(posedge i_clk); while (!s_ready);
        predicted = queue_outcome(req, handle, prio);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic random_request(input int push_pct);
        logic [fwpe_pkg::REQ_W-1:0]  req;
        logic [fwpe_pkg::PRIO_W-1:0] prio;
        int                          pick;
        pick = $urandom_range(99);
        if (pick < push_pct) begin
            req = fwpe_pkg::REQ_PUSH;
        end else begin
            pick = $urandom_range(99);
            req = (pick < 45) ? fwpe_pkg::REQ_POP :
                  (pick < 95) ? fwpe_pkg::REQ_REMOVE_MIN : REQ_UNUSED;
        end
        // narrow priorities now and then so ties show up
        if ($urandom_range(3) == 0)
            prio = fwpe_pkg::PRIO_W'($urandom_range(3));
        else
            prio = fwpe_pkg::PRIO_W'($urandom_range(255));
        send_request(req, $urandom, prio, 1'b0, '0);
    endtask

    // Result side: check each beat, then pick tready for the next edge.
    initial begin
        t_result got;
        t_result want;
        int      hold_left;
        int      hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_valid && m_ready) begin
                got.handle = m_tdata[fwpe_pkg::HANDLE_W-1:0];
                got.count  = m_tdata[fwpe_pkg::HANDLE_W +: fwpe_pkg::COUNT_W];
                got.valid  = m_tuser[0];
                got.status = m_tuser[1 +: fwpe_pkg::STATUS_W];
                beats_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", got.handle, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.handle !== want.handle)
                        report_mismatch("out_handle", got.handle, want.handle);
                    if (got.valid !== want.valid)
                        report_mismatch("out_valid", 32'(got.valid), 32'(want.valid));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    t_table_row directed_rows[15];

    initial begin
        int idle_pct[4];
        int stall_pct[4];
        int push_pct;
        idle_pct  = '{0, 80, 0, 14};
        stall_pct = '{0, 0, 80, 14};

        directed_rows = '{
            '{fwpe_pkg::REQ_POP, 32'h0, 8'h00, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_EMPTY, 5'd0}},
            '{fwpe_pkg::REQ_REMOVE_MIN, 32'h0, 8'h00, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_EMPTY, 5'd0}},
            '{REQ_UNUSED, 32'h0, 8'h00, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_OK, 5'd0}},
            '{fwpe_pkg::REQ_PUSH, 32'h0, 8'h00, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_OK, 5'd1}},
            '{fwpe_pkg::REQ_PUSH, 32'hFFFFFFFF, 8'hFF, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_OK, 5'd2}},
            '{fwpe_pkg::REQ_PUSH,       32'hA5A5A5A5, 8'h80, 1'b0, '0},
            '{fwpe_pkg::REQ_PUSH,       32'h5A5A5A5A, 8'h00, 1'b0, '0},
            '{fwpe_pkg::REQ_PUSH,       32'h12345678, 8'h7F, 1'b0, '0},
            '{fwpe_pkg::REQ_REMOVE_MIN, 32'h0,        8'h00, 1'b0, '0},
            '{fwpe_pkg::REQ_REMOVE_MIN, 32'h0,        8'h00, 1'b0, '0},
            '{REQ_UNUSED,               32'hFFFFFFFF, 8'hFF, 1'b0, '0},
            '{fwpe_pkg::REQ_POP,        32'h0,        8'h00, 1'b0, '0},
            '{fwpe_pkg::REQ_REMOVE_MIN, 32'h0,        8'h00, 1'b0, '0},
            '{fwpe_pkg::REQ_POP,        32'h0,        8'h00, 1'b0, '0},
            '{fwpe_pkg::REQ_POP, 32'h0, 8'h00, 1'b1,
              '{32'h0, 1'b0, fwpe_pkg::STAT_EMPTY, 5'd0}}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].handle, directed_rows[i].prio,
                         directed_rows[i].typed, directed_rows[i].want);

        // Hold the result side off and keep offering beats: fill past full, then drain.
        hold_requests++;
        repeat (DEPTH + 1) random_request(100);
        repeat (DEPTH + 1) send_request(fwpe_pkg::REQ_REMOVE_MIN, $urandom, 8'h00, 1'b0, '0);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // swing between filling and draining in stretches of 40
                case ((n / 40) % 3)
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                random_request(push_pct);
            end
        end
        s_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d requests, %0d result beats: %0d stored, %0d refused full, %0d removed",
                 items_sent, beats_seen, pushes_stored, full_refusals, entries_taken);
        $display("Empty results %0d, ignored requests %0d, four idling phases plus a long hold",
                 empty_results, ignored_reqs);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
